FILE: hdl/sxq_pkg.sv
//------------------------------------------------------------------------------
// sxq_pkg
// shared widths, request codes and sequencer states of the sorted expiry queue
//------------------------------------------------------------------------------
package sxq_pkg;

	localparam int DEPTH_DEF   = 16;
	localparam int MAX_RESULTS = 16;
	localparam int OP_W        = 3;
	localparam int TIME_W      = 32;
	localparam int KEY_W       = 32;
	localparam int COUNT_W     = 5;

	typedef enum logic [OP_W-1:0] {
		OP_ADD    = 3'd0,
		OP_UPDATE = 3'd1,
		OP_DELETE = 3'd2,
		OP_EXPIRE = 3'd3,
		OP_CLEAR  = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PROC,
		ST_XFETCH,
		ST_XPROC,
		ST_DONE
	} state_t;

endpackage

FILE: hdl/sxq_in_if.sv
//------------------------------------------------------------------------------
// sxq_in_if
// request channel of the sorted expiry queue
//------------------------------------------------------------------------------
interface sxq_in_if;
	import sxq_pkg::*;

	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [TIME_W-1:0] now_seconds;
	logic [TIME_W-1:0] time_value;
	logic [KEY_W-1:0]  entry_key;

	modport source (output valid, op, now_seconds, time_value, entry_key, input ready);
	modport sink   (input valid, op, now_seconds, time_value, entry_key, output ready);

endinterface

FILE: hdl/sxq_out_if.sv
//------------------------------------------------------------------------------
// sxq_out_if
// result channel of the sorted expiry queue
//------------------------------------------------------------------------------
interface sxq_out_if;
	import sxq_pkg::*;

	logic               valid;
	logic               ready;
	logic               ok;
	logic [KEY_W-1:0]   expired_key;
	logic [COUNT_W-1:0] entry_count;
	logic [TIME_W-1:0]  first_deadline;
	logic               last;

	modport source (output valid, ok, expired_key, entry_count, first_deadline, last,
		input ready);
	modport sink   (input valid, ok, expired_key, entry_count, first_deadline, last,
		output ready);

endinterface

FILE: hdl/sxq_ram.sv
//------------------------------------------------------------------------------
// sxq_ram
// simple dual-port ram, one write port and one read port with registered data
//------------------------------------------------------------------------------
module sxq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hdl/sorted_expiry_queue.sv
//------------------------------------------------------------------------------
// sorted_expiry_queue
// deadline-ordered timer store with add, update, delete, expire and clear
//------------------------------------------------------------------------------
// Entries live in one ram split into two banks; add, update, delete and
// expire stream the current bank through one compare unit into the other
// bank and swap banks if the request took effect; clear just empties the
// store. The single ram read port sets the rate: each stored entry is first
// addressed, then compared. Expired keys go out on the result channel during
// the pass, which a stall on that channel holds. One request is handled at a
// time.
//------------------------------------------------------------------------------
module sorted_expiry_queue #(
	parameter int DEPTH = sxq_pkg::DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	sxq_in_if.sink    req,
	sxq_out_if.source rsp
);
	import sxq_pkg::*;

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ENT_W  = TIME_W + KEY_W;
	localparam int RAM_D  = 2 << IDX_W;

	state_t state_q, state_d;

	logic              bank_q;
	logic [CNT_W-1:0]  held_q;
	logic [TIME_W-1:0] head_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  wr_q;
	logic [CNT_W-1:0]  n_q;
	logic              ins_q;
	logic              hit_q;
	logic              ok_q;
	logic [OP_W-1:0]   op_q;
	logic [TIME_W-1:0] dl_q;
	logic [TIME_W-1:0] tv_q;
	logic [KEY_W-1:0]  key_q;
	logic [TIME_W-1:0] first_q;

	logic               ovalid_q;
	logic               ook_q;
	logic [KEY_W-1:0]   okey_q;
	logic [COUNT_W-1:0] ocnt_q;
	logic [TIME_W-1:0]  ofirst_q;
	logic               olast_q;

	logic [ENT_W-1:0]  rdata;
	logic [ENT_W-1:0]  wdata;
	logic [TIME_W-1:0] rd_dl;
	logic [KEY_W-1:0]  rd_key;
	logic [TIME_W:0]   sum;
	logic [TIME_W-1:0] new_dl;

	logic accept, out_free, is_ins_op, append;
	logic we, wsel_new, adv_rd, adv_wr, set_ins, set_hit;
	logic emit_x, emit_done, pass_end, scan_stop, commit;
	logic [TIME_W-1:0] stop_head;
	logic [CNT_W-1:0]  wr_end;

	assign rd_dl     = rdata[ENT_W-1:KEY_W];
	assign rd_key    = rdata[KEY_W-1:0];
	assign wdata     = wsel_new ? {dl_q, key_q} : rdata;
	assign sum       = {1'b0, req.now_seconds} + {1'b0, req.time_value};
	assign new_dl    = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
	assign out_free  = !ovalid_q || rsp.ready;
	assign is_ins_op = (op_q == OP_ADD) || (op_q == OP_UPDATE);
	assign append    = is_ins_op && !ins_q;
	assign wr_end    = wr_q + CNT_W'(append);
	assign commit    = (op_q == OP_ADD) || (op_q == OP_EXPIRE) || hit_q;
	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;

	sxq_ram #(
		.WIDTH (ENT_W),
		.DEPTH (RAM_D)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr ({~bank_q, wr_q[IDX_W-1:0]}),
		.wdata (wdata),
		.raddr ({bank_q, idx_q[IDX_W-1:0]}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		we        = 1'b0;
		wsel_new  = 1'b0;
		adv_rd    = 1'b0;
		adv_wr    = 1'b0;
		set_ins   = 1'b0;
		set_hit   = 1'b0;
		emit_x    = 1'b0;
		emit_done = 1'b0;
		pass_end  = 1'b0;
		scan_stop = 1'b0;
		stop_head = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.op)
						OP_ADD:    state_d = (32'(held_q) < DEPTH) ? ST_FETCH : ST_DONE;
						OP_UPDATE: state_d = (req.entry_key != '0) ? ST_FETCH : ST_DONE;
						OP_DELETE: state_d = (req.entry_key != '0) ? ST_FETCH : ST_DONE;
						OP_EXPIRE: state_d = ST_XFETCH;
						default:   state_d = ST_DONE;
					endcase
				end
			end
			ST_FETCH: begin
				if (idx_q == held_q) begin
					pass_end = 1'b1;
					if (append) begin
						we       = (32'(wr_q) < DEPTH);
						wsel_new = 1'b1;
					end
					state_d = (op_q == OP_EXPIRE) ? ST_IDLE : ST_DONE;
				end else begin
					state_d = ST_PROC;
				end
			end
			ST_PROC: begin
				if (op_q == OP_EXPIRE && idx_q < n_q) begin
					if (out_free) begin
						emit_x  = 1'b1;
						adv_rd  = 1'b1;
						state_d = ST_FETCH;
					end
				end else if (op_q == OP_UPDATE && !hit_q && rd_key == key_q) begin
					set_hit = 1'b1;
					adv_rd  = 1'b1;
					state_d = ST_FETCH;
				end else if (op_q == OP_DELETE && rd_dl == tv_q && rd_key == key_q) begin
					set_hit = 1'b1;
					adv_rd  = 1'b1;
					state_d = ST_FETCH;
				end else if (append && rd_dl >= dl_q) begin
					// new entry goes ahead of this one, which is compared again
					we       = (32'(wr_q) < DEPTH);
					wsel_new = 1'b1;
					adv_wr   = 1'b1;
					set_ins  = 1'b1;
				end else begin
					we      = (32'(wr_q) < DEPTH);
					adv_wr  = 1'b1;
					adv_rd  = 1'b1;
					state_d = ST_FETCH;
				end
			end
			ST_XFETCH: begin
				if (idx_q == held_q) begin
					scan_stop = 1'b1;
					state_d   = (idx_q == '0) ? ST_DONE : ST_FETCH;
				end else begin
					state_d = ST_XPROC;
				end
			end
			ST_XPROC: begin
				if (rd_dl <= tv_q && 32'(idx_q) < MAX_RESULTS) begin
					adv_rd  = 1'b1;
					state_d = ST_XFETCH;
				end else begin
					scan_stop = 1'b1;
					stop_head = rd_dl;
					state_d   = (idx_q == '0) ? ST_DONE : ST_FETCH;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					emit_done = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer counters and store bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			held_q <= '0;
			head_q <= '0;
			idx_q  <= '0;
			wr_q   <= '0;
			n_q    <= '0;
			ins_q  <= 1'b0;
			hit_q  <= 1'b0;
			ok_q   <= 1'b0;
		end else begin
			if (accept) begin
				idx_q <= '0;
				wr_q  <= '0;
				n_q   <= '0;
				ins_q <= 1'b0;
				hit_q <= 1'b0;
				ok_q  <= 1'b0;
				if (req.op == OP_CLEAR) begin
					held_q <= '0;
					head_q <= '0;
					ok_q   <= 1'b1;
				end
			end
			if (adv_rd) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (adv_wr) begin
				wr_q <= wr_q + CNT_W'(1);
			end
			if (set_ins) begin
				ins_q <= 1'b1;
			end
			if (set_hit) begin
				hit_q <= 1'b1;
			end
			if (scan_stop) begin
				n_q    <= idx_q;
				idx_q  <= '0;
				head_q <= stop_head;
			end
			if (pass_end) begin
				ok_q <= (op_q == OP_ADD) || hit_q;
				if (commit) begin
					bank_q <= ~bank_q;
					held_q <= wr_end;
					if (op_q != OP_EXPIRE) begin
						head_q <= (we && wr_q == '0) ? dl_q : first_q;
					end
				end
			end
		end
	end

	// request payload and first written deadline
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			dl_q    <= new_dl;
			tv_q    <= req.time_value;
			key_q   <= req.entry_key;
			first_q <= '0;
		end else if (we && wr_q == '0) begin
			first_q <= wdata[ENT_W-1:KEY_W];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (emit_x || emit_done) begin
			ovalid_q <= 1'b1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_x) begin
			ook_q    <= 1'b1;
			okey_q   <= rd_key;
			ocnt_q   <= COUNT_W'(held_q - n_q);
			ofirst_q <= head_q;
			olast_q  <= (idx_q + CNT_W'(1) == n_q);
		end else if (emit_done) begin
			ook_q    <= ok_q;
			okey_q   <= '0;
			ocnt_q   <= COUNT_W'(held_q);
			ofirst_q <= head_q;
			olast_q  <= 1'b1;
		end
	end

	assign rsp.valid          = ovalid_q;
	assign rsp.ok             = ook_q;
	assign rsp.expired_key    = okey_q;
	assign rsp.entry_count    = ocnt_q;
	assign rsp.first_deadline = ofirst_q;
	assign rsp.last           = olast_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(held_q) <= DEPTH)
		else $error("entry count above depth");

	a_wr_behind_rd: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wr_q) <= 32'(idx_q) + 1)
		else $error("write index ran ahead of read index");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("request accepted without starting work");

	a_swap_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		bank_q != $past(bank_q) |-> $past(state_q) == ST_FETCH)
		else $error("bank swap outside end of pass");

endmodule
